// ===== hdl/dps_pkg.sv =====
// Shared types and constants for the dynamic priority scheduler.
// Used by dynamic_priority_scheduler and the bench; depends on nothing.
`default_nettype none

package dps_pkg;

	localparam int SLOTS_DEFAULT = 16;

	// Slot status codes.
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	// Result event codes.
	localparam logic [2:0] EV_IDLE      = 3'd0;
	localparam logic [2:0] EV_CONTINUED = 3'd1;
	localparam logic [2:0] EV_FINISHED  = 3'd2;
	localparam logic [2:0] EV_PREEMPTED = 3'd3;
	localparam logic [2:0] EV_ADDED     = 3'd4;
	localparam logic [2:0] EV_REJECTED  = 3'd5;

	// Input operation codes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes and reset values.
	localparam logic       REG_TIME_QUANTUM  = 1'b0;
	localparam logic       REG_PRIORITY_STEP = 1'b1;
	localparam logic [7:0] QUANTUM_RESET     = 8'd10;
	localparam logic [7:0] STEP_RESET        = 8'd10;

	localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

	// One task slot as held in the slot memory.
	typedef struct packed {
		logic signed [15:0] prio;
		logic [15:0]        used;
		logic [15:0]        rem;
		logic [3:0]         tag;
		logic [15:0]        arr;
	} slot_word_t;

	localparam int SLOT_WORD_W = $bits(slot_word_t);

endpackage

`default_nettype wire

// ===== hdl/dynamic_priority_scheduler.sv =====
// Top level of the dynamic priority preemptive scheduler.
// Depends on dps_pkg and dps_ram (task slot table).
//
// Usage: an input word with op = add places a task (tag, start priority,
// need time) into the lowest empty slot; op = tick runs one scheduler
// quantum. Every input word yields exactly one output word on the
// valid/ready output channel. Configuration (time quantum, priority step)
// is written through cfg_write/cfg_index/cfg_data while the block is idle.
//
// Timing: in_ready is high only between items. An add searches the slots for
// a free one (one slot of the free-slot search per cycle). A tick with a task
// already running charges that task and then scans the slots; starting from
// idle and a preemption each add a further scan pass. Each pass reads one
// slot per cycle through a single compare unit, so the slot count sets the
// length of a tick.
// Reset empties every slot, stops the running task, restores both
// registers to 10 and clears the arrival counter. The output word sits in
// its own register: the next input word is accepted while it waits, and
// the block holds its next result until the receiver takes the old one.
`default_nettype none

module dynamic_priority_scheduler
	import dps_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic [3:0]         task_tag,
	input  wire logic signed [15:0] start_priority,
	input  wire logic [15:0]        need_time,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              event_res,
	output logic [3:0]              ran_tag,
	output logic [15:0]             used_time,
	output logic [15:0]             remaining_time,
	output logic signed [15:0]      current_priority,
	output logic                    next_valid,
	output logic [3:0]              next_tag
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int CNTW = IDXW + 1;
	localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ADD_FIND = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_UPD_RD   = 4'd4;
	localparam logic [3:0] S_UPD_CALC = 4'd5;
	localparam logic [3:0] S_FIN      = 4'd6;

	localparam logic [1:0] PH_START0    = 2'd0;
	localparam logic [1:0] PH_AFTER_UPD = 2'd1;
	localparam logic [1:0] PH_AFTER_PRE = 2'd2;

	// control state
	logic [3:0]      state_q;
	logic [1:0]      phase_q;
	logic [1:0]      status_q [SLOTS];
	logic            running_valid_q;
	logic [IDXW-1:0] run_slot_q;
	logic [3:0]      run_tag_q;
	logic [15:0]     counter_q;
	logic [7:0]      quantum_q;
	logic [7:0]      step_q;
	logic [CNTW-1:0] scan_idx_q;
	logic            busy_s1;
	logic            best_found_q;
	logic            out_valid_q;

	// payload registers
	logic [3:0]         in_tag_q;
	logic signed [15:0] in_prio_q;
	logic [15:0]        in_need_q;
	logic [IDXW-1:0]    cand_idx_s1;
	logic [IDXW-1:0]    best_idx_q;
	logic signed [15:0] best_prio_q;
	logic [15:0]        best_age_q;
	logic [3:0]         best_tag_q;
	slot_word_t         upd_q;
	logic               done_q;
	logic [2:0]         res_ev_q;
	logic [3:0]         res_tag_q;
	logic [15:0]        res_used_q;
	logic [15:0]        res_rem_q;
	logic signed [15:0] res_prio_q;
	logic [2:0]         out_ev_q;
	logic [3:0]         out_tag_q;
	logic [15:0]        out_used_q;
	logic [15:0]        out_rem_q;
	logic signed [15:0] out_prio_q;
	logic               out_next_valid_q;
	logic [3:0]         out_next_tag_q;

	// memory port signals
	logic                   ram_we;
	logic [IDXW-1:0]        ram_waddr;
	slot_word_t             ram_wword;
	logic [IDXW-1:0]        ram_raddr;
	logic [SLOT_WORD_W-1:0] ram_rdata;
	slot_word_t             rd_word;

	// combinational helpers
	logic               accept;
	logic               in_range;
	logic [1:0]         idx_status;
	logic               issuing;
	logic               scan_done;
	logic [15:0]        cand_age;
	logic               cand_better;
	logic               add_found;
	logic               preempt;
	logic               out_free;
	logic [16:0]        used_sum;
	logic signed [16:0] prio_diff;
	logic               rem_done;
	slot_word_t         calc_word;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign in_range  = (scan_idx_q < SLOTS_C);
	assign idx_status = in_range ? status_q[scan_idx_q[IDXW-1:0]] : ST_EMPTY;
	assign issuing   = (state_q == S_SCAN) && in_range;
	assign scan_done = (state_q == S_SCAN) && !in_range && !busy_s1;
	assign add_found = (state_q == S_ADD_FIND) && in_range && (idx_status == ST_EMPTY);
	assign rd_word   = slot_word_t'(ram_rdata);

	// The shared compare unit: one candidate slot per cycle against the best so far.
	// Ties go to the larger age, which is the earlier arrival.
	assign cand_age    = counter_q - rd_word.arr;
	assign cand_better = !best_found_q || (rd_word.prio > best_prio_q) ||
		((rd_word.prio == best_prio_q) && (cand_age > best_age_q));

	assign preempt = !done_q && best_found_q && (upd_q.prio < best_prio_q);

	// Charge of the running task: saturating used time and priority.
	always_comb begin
		used_sum  = {1'b0, rd_word.used} + {9'd0, quantum_q};
		prio_diff = {rd_word.prio[15], rd_word.prio} - $signed({9'd0, step_q});
		rem_done  = (rd_word.rem <= {8'd0, quantum_q});
		calc_word = rd_word;
		calc_word.used = used_sum[16] ? 16'hFFFF : used_sum[15:0];
		calc_word.prio = (prio_diff[16] != prio_diff[15]) ? PRIO_MIN : prio_diff[15:0];
		calc_word.rem  = rem_done ? 16'd0 : (rd_word.rem - {8'd0, quantum_q});
	end

	// Memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = run_slot_q;
		ram_wword = upd_q;
		ram_raddr = (state_q == S_UPD_RD) ? run_slot_q : scan_idx_q[IDXW-1:0];
		if (add_found) begin
			ram_we         = 1'b1;
			ram_waddr      = scan_idx_q[IDXW-1:0];
			ram_wword.prio = in_prio_q;
			ram_wword.used = 16'd0;
			ram_wword.rem  = in_need_q;
			ram_wword.tag  = in_tag_q;
			ram_wword.arr  = counter_q;
		end else if ((state_q == S_DECIDE) && (phase_q == PH_AFTER_UPD)) begin
			ram_we = 1'b1;
			if (preempt) begin
				ram_wword.arr = counter_q;
			end
		end
	end

	dps_ram #(
		.WIDTH(SLOT_WORD_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(SLOT_WORD_W'(ram_wword)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
			step_q    <= STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TIME_QUANTUM:  quantum_q <= cfg_data;
				REG_PRIORITY_STEP: step_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and slot status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			phase_q         <= PH_START0;
			running_valid_q <= 1'b0;
			run_slot_q      <= '0;
			run_tag_q       <= 4'd0;
			counter_q       <= 16'd0;
			scan_idx_q      <= '0;
			busy_s1         <= 1'b0;
			best_found_q    <= 1'b0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= ST_EMPTY;
			end
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_idx_q   <= '0;
						busy_s1      <= 1'b0;
						best_found_q <= 1'b0;
						phase_q      <= PH_START0;
						if (op == OP_ADD) begin
							state_q <= S_ADD_FIND;
						end else if (running_valid_q) begin
							state_q <= S_UPD_RD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_ADD_FIND: begin
					if (!in_range) begin
						state_q <= S_FIN;
					end else if (add_found) begin
						status_q[scan_idx_q[IDXW-1:0]] <= ST_READY;
						counter_q <= counter_q + 16'd1;
						state_q   <= S_FIN;
					end else begin
						scan_idx_q <= scan_idx_q + CNTW'(1);
					end
				end
				S_SCAN: begin
					busy_s1 <= issuing && (idx_status == ST_READY);
					if (issuing) begin
						scan_idx_q <= scan_idx_q + CNTW'(1);
					end
					if (busy_s1 && cand_better) begin
						best_found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (phase_q)
						PH_START0: begin
							if (best_found_q) begin
								status_q[best_idx_q] <= ST_RUN;
								run_slot_q      <= best_idx_q;
								run_tag_q       <= best_tag_q;
								running_valid_q <= 1'b1;
								state_q         <= S_UPD_RD;
							end else begin
								state_q <= S_FIN;
							end
						end
						PH_AFTER_UPD: begin
							if (done_q) begin
								status_q[run_slot_q] <= ST_EMPTY;
								if (best_found_q) begin
									status_q[best_idx_q] <= ST_RUN;
									run_slot_q      <= best_idx_q;
									run_tag_q       <= best_tag_q;
									running_valid_q <= 1'b1;
								end else begin
									run_slot_q      <= '0;
									running_valid_q <= 1'b0;
								end
								state_q <= S_FIN;
							end else if (preempt) begin
								// Requeue the charged task and run the scan again,
								// since the arrival counter moved.
								status_q[run_slot_q] <= ST_READY;
								counter_q       <= counter_q + 16'd1;
								running_valid_q <= 1'b0;
								scan_idx_q      <= '0;
								busy_s1         <= 1'b0;
								best_found_q    <= 1'b0;
								phase_q         <= PH_AFTER_PRE;
								state_q         <= S_SCAN;
							end else begin
								state_q <= S_FIN;
							end
						end
						PH_AFTER_PRE: begin
							if (best_found_q) begin
								status_q[best_idx_q] <= ST_RUN;
								run_slot_q      <= best_idx_q;
								run_tag_q       <= best_tag_q;
								running_valid_q <= 1'b1;
							end else begin
								run_slot_q      <= '0;
								running_valid_q <= 1'b0;
							end
							state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_UPD_RD: begin
					state_q <= S_UPD_CALC;
				end
				S_UPD_CALC: begin
					scan_idx_q   <= '0;
					busy_s1      <= 1'b0;
					best_found_q <= 1'b0;
					phase_q      <= PH_AFTER_UPD;
					state_q      <= S_SCAN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_tag_q  <= task_tag;
			in_prio_q <= start_priority;
			in_need_q <= need_time;
		end

		if (issuing) begin
			cand_idx_s1 <= scan_idx_q[IDXW-1:0];
		end
		if ((state_q == S_SCAN) && busy_s1 && cand_better) begin
			best_idx_q  <= cand_idx_s1;
			best_prio_q <= rd_word.prio;
			best_age_q  <= cand_age;
			best_tag_q  <= rd_word.tag;
		end

		if (state_q == S_UPD_CALC) begin
			upd_q  <= calc_word;
			done_q <= rem_done;
		end

		if (state_q == S_ADD_FIND) begin
			res_tag_q  <= in_tag_q;
			res_used_q <= 16'd0;
			if (add_found) begin
				res_ev_q   <= EV_ADDED;
				res_rem_q  <= in_need_q;
				res_prio_q <= in_prio_q;
			end else begin
				res_ev_q   <= EV_REJECTED;
				res_rem_q  <= 16'd0;
				res_prio_q <= 16'sd0;
			end
		end

		if (state_q == S_DECIDE) begin
			if ((phase_q == PH_START0) && !best_found_q) begin
				res_ev_q   <= EV_IDLE;
				res_tag_q  <= 4'd0;
				res_used_q <= 16'd0;
				res_rem_q  <= 16'd0;
				res_prio_q <= 16'sd0;
			end else if (phase_q == PH_AFTER_UPD) begin
				res_tag_q  <= upd_q.tag;
				res_used_q <= upd_q.used;
				res_rem_q  <= upd_q.rem;
				res_prio_q <= upd_q.prio;
				if (done_q) begin
					res_ev_q <= EV_FINISHED;
				end else if (preempt) begin
					res_ev_q <= EV_PREEMPTED;
				end else begin
					res_ev_q <= EV_CONTINUED;
				end
			end
		end

		if ((state_q == S_FIN) && out_free) begin
			out_ev_q         <= res_ev_q;
			out_tag_q        <= res_tag_q;
			out_used_q       <= res_used_q;
			out_rem_q        <= res_rem_q;
			out_prio_q       <= res_prio_q;
			out_next_valid_q <= running_valid_q;
			out_next_tag_q   <= running_valid_q ? run_tag_q : 4'd0;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_res        = out_ev_q;
	assign ran_tag          = out_tag_q;
	assign used_time        = out_used_q;
	assign remaining_time   = out_rem_q;
	assign current_priority = out_prio_q;
	assign next_valid       = out_next_valid_q;
	assign next_tag         = out_next_tag_q;

	// Between items the running slot must be marked as running.
	a_run_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && running_valid_q |-> status_q[run_slot_q] == ST_RUN)
		else $error("running slot not marked as running");

	// A requeued task guarantees that the rescan finds a ready task.
	a_pre_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && (phase_q == PH_AFTER_PRE) |-> best_found_q)
		else $error("rescan after preemption found no ready task");

	// An idle tick leaves nothing running.
	a_idle_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_IDLE) |-> !next_valid)
		else $error("idle word reports a running task");

	// The block is busy in the cycle after it takes an input word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous word in progress");

endmodule

`default_nettype wire

// ===== hdl/dps_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Standalone; holds the task slot table of the scheduler.
`default_nettype none

module dps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== test/dps_tb_pkg.sv =====
// Scoreboard for the dynamic priority scheduler bench: a software copy of the
// task slot table that predicts every output word and checks the DUT against it.
// Depends on dps_pkg for the status, event, operation and register codes.
package dps_tb_pkg;
	import dps_pkg::*;

	typedef struct packed {
		logic [2:0]         ev;
		logic [3:0]         tag;
		logic [15:0]        used;
		logic [15:0]        rem;
		logic signed [15:0] prio;
		logic               nv;
		logic [3:0]         ntag;
	} sched_word_t;

	class schedule_tracker;
		int unsigned        quantum;
		int unsigned        prio_step;
		logic signed [15:0] slot_prio [SLOTS_DEFAULT];
		logic [15:0]        slot_used [SLOTS_DEFAULT];
		logic [15:0]        slot_rem [SLOTS_DEFAULT];
		logic [15:0]        slot_arr [SLOTS_DEFAULT];
		logic [3:0]         slot_tag [SLOTS_DEFAULT];
		logic [1:0]         slot_state [SLOTS_DEFAULT];
		bit                 running;
		int                 run_idx;
		logic [15:0]        arrivals;
		sched_word_t        expected_words[$];
		int                 mismatches;
		int                 checked;
		int                 ev_seen[8];

		function new();
			quantum = 32'(QUANTUM_RESET);
			prio_step = 32'(STEP_RESET);
			foreach (slot_state[i])
				slot_state[i] = ST_EMPTY;
			running = 0;
			run_idx = 0;
			arrivals = 16'd0;
			mismatches = 0;
			checked = 0;
			foreach (ev_seen[i])
				ev_seen[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] val);
			if (idx == REG_TIME_QUANTUM) begin
				quantum = 32'(val);
			end else begin
				prio_step = 32'(val);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// Highest priority wins; on a tie the task that has waited longest wins.
		// Waiting time is taken modulo 2^16 so the order survives counter wrap.
		function int best_ready();
			int          b;
			logic [15:0] best_age;
			logic [15:0] age;
			b = -1;
			best_age = 16'd0;
			for (int i = 0; i < SLOTS_DEFAULT; i++) begin
				if (slot_state[i] == ST_READY) begin
					age = arrivals - slot_arr[i];
					if (b < 0 || slot_prio[i] > slot_prio[b] ||
					    (slot_prio[i] == slot_prio[b] && age > best_age)) begin
						b = i;
						best_age = age;
					end
				end
			end
			return b;
		endfunction

		function void requeue(int s);
			slot_state[s] = ST_READY;
			slot_arr[s] = arrivals;
			arrivals = arrivals + 16'd1;
		endfunction

		function void dispatch();
			int b;
			b = best_ready();
			if (b >= 0) begin
				slot_state[b] = ST_RUN;
				run_idx = b;
				running = 1;
			end else begin
				running = 0;
				run_idx = 0;
			end
		endfunction

		function void note_accepted(logic o, logic [3:0] t, logic signed [15:0] p,
		                            logic [15:0] n);
			sched_word_t w;
			int          s;
			int          b;
			int          u;
			int          q;
			bit          done;
			w = '0;
			if (o == OP_ADD) begin
				s = -1;
				for (int i = SLOTS_DEFAULT - 1; i >= 0; i--)
					if (slot_state[i] == ST_EMPTY)
						s = i;
				w.tag = t;
				if (s < 0) begin
					w.ev = EV_REJECTED;
				end else begin
					slot_tag[s] = t;
					slot_prio[s] = p;
					slot_used[s] = 16'd0;
					slot_rem[s] = n;
					requeue(s);
					w.ev = EV_ADDED;
					w.rem = n;
					w.prio = p;
				end
			end else begin
				if (!running)
					dispatch();
				if (running) begin
					s = run_idx;
					u = int'(slot_used[s]) + int'(quantum);
					slot_used[s] = (u > 65535) ? 16'hFFFF : u[15:0];
					q = int'(slot_prio[s]) - int'(prio_step);
					slot_prio[s] = (q < -32768) ? PRIO_MIN : q[15:0];
					done = slot_rem[s] <= quantum;
					slot_rem[s] = done ? 16'd0 : slot_rem[s] - quantum[15:0];
					w.tag = slot_tag[s];
					w.used = slot_used[s];
					w.rem = slot_rem[s];
					w.prio = slot_prio[s];
					if (done) begin
						slot_state[s] = ST_EMPTY;
						running = 0;
						dispatch();
						w.ev = EV_FINISHED;
					end else begin
						b = best_ready();
						// Only a strictly better ready task takes the processor away.
						if (b >= 0 && slot_prio[s] < slot_prio[b]) begin
							requeue(s);
							running = 0;
							dispatch();
							w.ev = EV_PREEMPTED;
						end else begin
							w.ev = EV_CONTINUED;
						end
					end
				end else begin
					w.ev = EV_IDLE;
				end
			end
			w.nv = running;
			w.ntag = running ? slot_tag[run_idx] : 4'd0;
			expected_words.push_back(w);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(sched_word_t got);
			sched_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: output word with nothing expected, expected none, got event %0h tag %0h",
				         $time, got.ev, got.tag);
				return;
			end
			want = expected_words.pop_front();
			checked++;
			ev_seen[want.ev]++;
			check_field("event_res", 16'(want.ev), 16'(got.ev));
			check_field("ran_tag", 16'(want.tag), 16'(got.tag));
			check_field("used_time", want.used, got.used);
			check_field("remaining_time", want.rem, got.rem);
			check_field("current_priority", want.prio, got.prio);
			check_field("next_valid", 16'(want.nv), 16'(got.nv));
			check_field("next_tag", 16'(want.ntag), 16'(got.ntag));
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
// Top of the dynamic priority scheduler bench: clock, reset, stimulus and the
// output receiver. Depends on dps_pkg, dps_tb_pkg and the scheduler RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dps_pkg::*;
	import dps_tb_pkg::*;

	localparam int LATENCY_CYCLES = 100;
	localparam int RUN_LIMIT_NS = 6_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [3:0]         task_tag;
	logic signed [15:0] start_priority;
	logic [15:0]        need_time;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         event_res;
	logic [3:0]         ran_tag;
	logic [15:0]        used_time;
	logic [15:0]        remaining_time;
	logic signed [15:0] current_priority;
	logic               next_valid;
	logic [3:0]         next_tag;

	schedule_tracker tracker = new();
	bit tx_fast;
	bit rx_fast;
	bit rx_long_hold;
	int words_sent;

	dynamic_priority_scheduler u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("dynamic_priority_scheduler regression: fail");
		$finish;
	end

	// Receiver: waits a random number of cycles before each word (none in fast
	// stretches), or a long stretch on request so the scheduler backs up into its input.
	initial begin
		int          hold;
		int          taken;
		sched_word_t got;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_long_hold) begin
				hold = 400;
				rx_long_hold = 0;
			end else if (rx_fast) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 16);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.ev = event_res;
			got.tag = ran_tag;
			got.used = used_time;
			got.rem = remaining_time;
			got.prio = current_priority;
			got.nv = next_valid;
			got.ntag = next_tag;
			tracker.check_result(got);
			taken++;
			if (taken % 64 == 0)
				rx_fast = ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_word(input logic o, input logic [3:0] t,
	                         input logic signed [15:0] p, input logic [15:0] n);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= o;
		task_tag <= t;
		start_priority <= p;
		need_time <= n;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		tracker.note_accepted(o, t, p, n);
		words_sent++;
		if (words_sent % 64 == 0)
			tx_fast = ($urandom_range(0, 3) == 0);
	endtask

	// Stop offering words and wait for every predicted result, then settle.
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] q, input logic [7:0] s);
		cfg_write <= 1'b1;
		cfg_index <= REG_TIME_QUANTUM;
		cfg_data <= q;
		@(posedge clk);
		tracker.write_reg(REG_TIME_QUANTUM, q);
		cfg_index <= REG_PRIORITY_STEP;
		cfg_data <= s;
		@(posedge clk);
		tracker.write_reg(REG_PRIORITY_STEP, s);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small priorities and short jobs so tasks tie, preempt and finish;
	// now and then an extreme priority or a long job.
	task automatic send_random(input int add_pct);
		logic               o;
		logic [3:0]         t;
		logic signed [15:0] p;
		logic [15:0]        n;
		int                 r;
		int                 q_eff;
		o = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
		t = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: p = 16'sh7FFF;
				1: p = PRIO_MIN;
				2: p = 16'sh7FFE;
				default: p = 16'sh8001;
			endcase
		end else if (r < 3) begin
			p = 16'($urandom);
		end else begin
			p = 16'(int'($urandom_range(0, 40)) - 20);
		end
		r = $urandom_range(0, 199);
		q_eff = (tracker.quantum == 0) ? 1 : tracker.quantum;
		if (r < 8) begin
			n = 16'd0;
		end else if (r < 9) begin
			n = 16'hFFFF;
		end else if (r < 11) begin
			n = 16'($urandom);
		end else begin
			n = 16'($urandom_range(1, 6 * q_eff));
		end
		send_word(o, t, p, n);
	endtask

	task automatic run_phase(input logic [7:0] q, input logic [7:0] s, input int count);
		int add_pct;
		drain(LATENCY_CYCLES);
		set_regs(q, s);
		add_pct = 45;
		for (int k = 0; k < count; k++) begin
			if (k % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: add_pct = 25;
					1: add_pct = 45;
					default: add_pct = 70;
				endcase
			end
			if (k == count / 3)
				rx_long_hold = 1;
			if (k == 2 * count / 3)
				drain(0);
			send_random(add_pct);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_TIME_QUANTUM;
		cfg_data <= 8'd0;
		in_valid <= 1'b0;
		op <= OP_ADD;
		task_tag <= 4'd0;
		start_priority <= 16'sd0;
		need_time <= 16'd0;
		tx_fast = 0;
		rx_fast = 0;
		rx_long_hold = 0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset settings: an idle tick, extreme fields,
		// a duplicate tag with a tied priority, a preemption, a finish, a job
		// that needs no time, then a full table and a rejected add.
		send_word(OP_TICK, 4'd0, 16'sd0, 16'd0);
		send_word(OP_ADD, 4'd15, PRIO_MIN, 16'd0);
		send_word(OP_ADD, 4'd0, 16'sh7FFF, 16'hFFFF);
		send_word(OP_ADD, 4'd0, 16'sh7FFF, 16'd20);
		repeat (3) send_word(OP_TICK, 4'd0, 16'sd0, 16'd0);
		send_word(OP_ADD, 4'd5, 16'sd0, 16'd1);
		for (int i = 1; i <= 13; i++)
			send_word(OP_ADD, i[3:0], PRIO_MIN, i[15:0]);
		send_word(OP_ADD, 4'd7, 16'sh1234, 16'd99);
		repeat (3) send_word(OP_TICK, 4'd0, 16'sd0, 16'd0);

		run_phase(8'd10, 8'd10, 300);
		run_phase(8'd1, 8'd0, 200);
		run_phase(8'd255, 8'd255, 200);
		// A zero quantum charges no time, so only jobs needing no time finish.
		run_phase(8'd0, 8'd3, 40);

		// One top priority long job run to the end so its used time saturates.
		drain(LATENCY_CYCLES);
		set_regs(8'd254, 8'd0);
		send_word(OP_ADD, 4'd9, 16'sh7FFF, 16'hFFFF);
		repeat (300) send_word(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));

		run_phase(8'd1, 8'd255, 200);
		run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 150);
		run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 150);
		drain(LATENCY_CYCLES);

		$display("Sent %0d words, checked %0d results: %0d added, %0d rejected as full,",
		         words_sent, tracker.checked, tracker.ev_seen[EV_ADDED],
		         tracker.ev_seen[EV_REJECTED]);
		$display("%0d idle ticks, %0d continued, %0d finished, %0d preempted; %0d mismatches.",
		         tracker.ev_seen[EV_IDLE], tracker.ev_seen[EV_CONTINUED],
		         tracker.ev_seen[EV_FINISHED], tracker.ev_seen[EV_PREEMPTED],
		         tracker.mismatches);
		if (tracker.mismatches == 0) begin
			$display("dynamic_priority_scheduler regression: pass");
		end else begin
			$display("dynamic_priority_scheduler regression: fail");
		end
		$finish;
	end

endmodule
